>>> rtl/gprs_pkg.sv
// ----------------------------------------------------------------------------
// gprs_pkg
// Shared types and constants of the greedy pattern replace stream.
// ----------------------------------------------------------------------------
package gprs_pkg;

    // The pattern and replacement registers hold at most eight bytes.
    localparam int BYTES_MAX       = 8;
    localparam int MAX_PATTERN_DEF = 8;
    localparam int MAX_REPL_DEF    = 8;
    localparam int QUEUE_DEPTH     = 2;

    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_LEN   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_BYTES = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_REPL_LEN      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_REPL_BYTES    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_REPL_LABELS   = 3'd4;

    typedef struct packed {
        logic [7:0] lab;
        logic [7:0] ch;
    } atom_t;

    typedef struct packed {
        logic [3:0]  pattern_len;
        logic [63:0] pattern_bytes;
        logic [3:0]  repl_len;
        logic [63:0] repl_bytes;
        logic [63:0] repl_labels;
    } cfg_t;

    // One command for the back end: either the first count replacement atoms
    // or the first count atoms of a window snapshot.
    typedef struct packed {
        logic                  is_repl;
        logic                  last;
        logic [3:0]            count;
        atom_t [BYTES_MAX-1:0] atoms;
    } cmd_t;

endpackage

>>> rtl/gprs_front.sv
// ----------------------------------------------------------------------------
// gprs_front
// Accepts atoms, keeps the match window and pushes commands for atoms that yield words.
// ----------------------------------------------------------------------------
module gprs_front #(
    parameter int MAX_PATTERN = gprs_pkg::MAX_PATTERN_DEF,
    parameter int MAX_REPL    = gprs_pkg::MAX_REPL_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  gprs_pkg::cfg_t  cfg,
    input  logic            clear_fill,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_char,
    input  logic [7:0]      s_label,
    input  logic            s_last,
    input  logic            q_full,
    output logic            push_valid,
    output gprs_pkg::cmd_t  push_cmd
);

    localparam int WIN    = (MAX_PATTERN < gprs_pkg::BYTES_MAX) ? MAX_PATTERN
                                                                : gprs_pkg::BYTES_MAX;
    localparam int RLIM   = (MAX_REPL < gprs_pkg::BYTES_MAX) ? MAX_REPL
                                                             : gprs_pkg::BYTES_MAX;
    localparam int FILL_W = $clog2(WIN + 1);

    gprs_pkg::atom_t win_reg [WIN];
    gprs_pkg::atom_t ins     [WIN];
    gprs_pkg::atom_t shifted [WIN];
    gprs_pkg::atom_t new_atom;

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [3:0]        p_len, r_len, fill_ext;
    logic              accept, full, match;

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign new_atom = '{lab: s_label, ch: s_char};
    assign fill_ext = 4'(fill_reg);

    always_comb begin
        if (cfg.pattern_len == 4'd0) begin
            p_len = 4'd1;
        end else if (cfg.pattern_len > 4'(WIN)) begin
            p_len = 4'(WIN);
        end else begin
            p_len = cfg.pattern_len;
        end
        r_len = (cfg.repl_len > 4'(RLIM)) ? 4'(RLIM) : cfg.repl_len;
    end

    // Window with the new atom placed behind the atoms already held.
    always_comb begin
        for (int i = 0; i < WIN; i++) begin
            ins[i] = (fill_reg == FILL_W'(i)) ? new_atom : win_reg[i];
        end
        for (int i = 0; i < WIN - 1; i++) begin
            shifted[i] = ins[i + 1];
        end
        shifted[WIN-1] = ins[WIN-1];
    end

    always_comb begin
        full  = (fill_ext + 4'd1) >= p_len;
        match = 1'b1;
        for (int i = 0; i < WIN; i++) begin
            if (4'(i) < p_len && ins[i].ch != cfg.pattern_bytes[8*i +: 8]) begin
                match = 1'b0;
            end
        end
    end

    always_comb begin
        push_cmd         = '0;
        push_cmd.last    = s_last;
        for (int i = 0; i < WIN; i++) begin
            push_cmd.atoms[i] = ins[i];
        end
        push_valid = 1'b0;
        fill_next  = fill_reg;
        if (full && match) begin
            push_cmd.is_repl = 1'b1;
            push_cmd.count   = r_len;
            push_valid       = accept && (r_len != 4'd0);
            fill_next        = '0;
        end else if (full) begin
            // Mismatch: the oldest atom leaves, and on the last atom the rest follows.
            push_cmd.count = s_last ? p_len : 4'd1;
            push_valid     = accept;
            fill_next      = fill_reg;
        end else begin
            push_cmd.count = fill_ext + 4'd1;
            push_valid     = accept && s_last;
            fill_next      = fill_reg + FILL_W'(1);
        end
        if (s_last) begin
            fill_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (clear_fill) begin
            fill_reg <= '0;
        end else if (accept) begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < WIN; i++) begin
                win_reg[i] <= (full && !match) ? shifted[i] : ins[i];
            end
        end
    end

endmodule

>>> rtl/gprs_queue.sv
// ----------------------------------------------------------------------------
// gprs_queue
// Small command queue between the front and back ends.
// ----------------------------------------------------------------------------
module gprs_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  gprs_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output gprs_pkg::cmd_t  head_cmd,
    output logic            full,
    output logic            empty
);

    localparam int PTR_W = $clog2(gprs_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(gprs_pkg::QUEUE_DEPTH + 1);

    gprs_pkg::cmd_t    mem [gprs_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wptr_reg, rptr_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    assign full     = (cnt_reg == CNT_W'(gprs_pkg::QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign head_cmd = mem[rptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wptr_reg <= (wptr_reg == PTR_W'(gprs_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == PTR_W'(gprs_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/gprs_back.sv
// ----------------------------------------------------------------------------
// gprs_back
// Expands queued commands into result words, one per cycle while m_ready is high.
// ----------------------------------------------------------------------------
module gprs_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  gprs_pkg::cfg_t  cfg,
    input  logic            q_empty,
    input  gprs_pkg::cmd_t  head_cmd,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_char,
    output logic [7:0]      m_label,
    output logic            m_run_last,
    output logic            m_stream_end
);

    localparam int IDX_W = $clog2(gprs_pkg::BYTES_MAX);

    logic [IDX_W-1:0] idx_reg;
    logic             m_valid_reg;
    logic [7:0]       m_char_reg, m_label_reg;
    logic             m_run_last_reg, m_stream_end_reg;
    logic             load, run_last;
    gprs_pkg::atom_t  word;

    assign load     = !q_empty && (!m_valid_reg || m_ready);
    assign run_last = (4'(idx_reg) + 4'd1) == head_cmd.count;
    assign pop      = load && run_last;

    always_comb begin
        if (head_cmd.is_repl) begin
            word.ch  = cfg.repl_bytes[8*idx_reg +: 8];
            word.lab = cfg.repl_labels[8*idx_reg +: 8];
        end else begin
            word = head_cmd.atoms[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                idx_reg     <= run_last ? '0 : idx_reg + IDX_W'(1);
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_char_reg       <= word.ch;
            m_label_reg      <= word.lab;
            m_run_last_reg   <= run_last;
            m_stream_end_reg <= run_last && head_cmd.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_char       = m_char_reg;
    assign m_label      = m_label_reg;
    assign m_run_last   = m_run_last_reg;
    assign m_stream_end = m_stream_end_reg;

endmodule

>>> rtl/greedy_pattern_replace_stream.sv
// ----------------------------------------------------------------------------
// greedy_pattern_replace_stream
// Leftmost-first, non-overlapping find and replace over labelled characters.
//
//   Channel  Direction  Handshake                Payload
//   s_       in         s_valid / s_ready        s_char, s_label, s_last
//   m_       out        m_valid / m_ready        m_char, m_label, m_run_last,
//                                                m_stream_end
//   cfg_     in         cfg_valid / cfg_ready    cfg_addr, cfg_data
//
// An atom is accepted every cycle while the two-entry command queue has room;
// its words leave the output register one per cycle while m_ready is high,
// all of them before the words of the next command. The first word passes
// through the command queue and the output register. Reset is synchronous
// and clears the window, the queue and the output register; no clearing
// pass is needed. A stall on m_ready fills the queue and then drops s_ready.
// ----------------------------------------------------------------------------
module greedy_pattern_replace_stream #(
    parameter int MAX_PATTERN = gprs_pkg::MAX_PATTERN_DEF,
    parameter int MAX_REPL    = gprs_pkg::MAX_REPL_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_char,
    input  logic signed [7:0]               s_label,
    input  logic                            s_last,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_char,
    output logic signed [7:0]               m_label,
    output logic                            m_run_last,
    output logic                            m_stream_end,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gprs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [63:0]                     cfg_data
);

    gprs_pkg::cfg_t cfg_reg;
    gprs_pkg::cmd_t push_cmd, head_cmd;
    logic           cfg_write, clear_fill;
    logic           push_valid, q_full, q_empty, pop;
    logic [7:0]     m_label_raw;

    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign clear_fill = cfg_write && (cfg_addr == gprs_pkg::REG_PATTERN_LEN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern_len   <= 4'd1;
            cfg_reg.pattern_bytes <= '0;
            cfg_reg.repl_len      <= '0;
            cfg_reg.repl_bytes    <= '0;
            cfg_reg.repl_labels   <= '1;
        end else if (cfg_write) begin
            case (cfg_addr)
                gprs_pkg::REG_PATTERN_LEN:   cfg_reg.pattern_len   <= cfg_data[3:0];
                gprs_pkg::REG_PATTERN_BYTES: cfg_reg.pattern_bytes <= cfg_data;
                gprs_pkg::REG_REPL_LEN:      cfg_reg.repl_len      <= cfg_data[3:0];
                gprs_pkg::REG_REPL_BYTES:    cfg_reg.repl_bytes    <= cfg_data;
                gprs_pkg::REG_REPL_LABELS:   cfg_reg.repl_labels   <= cfg_data;
                default: ;
            endcase
        end
    end

    gprs_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_REPL    (MAX_REPL)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .clear_fill (clear_fill),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_char     (s_char),
        .s_label    (s_label),
        .s_last     (s_last),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    gprs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push_valid),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    gprs_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .q_empty      (q_empty),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_char       (m_char),
        .m_label      (m_label_raw),
        .m_run_last   (m_run_last),
        .m_stream_end (m_stream_end)
    );

    assign m_label = m_label_raw;

    // The front end never writes a command into a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> !q_full)
        else $error("command pushed into a full queue");

    // The back end only retires a command that is present.
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_empty)
        else $error("command popped from an empty queue");

    // The end of a stream always closes the run of words of its atom.
    a_end_closes_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_stream_end) |-> m_run_last)
        else $error("stream end on a word that does not close its run");

    // Reset empties the output register.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid right after reset");

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the greedy pattern replace stream.
//
// A clocked driver feeds atoms from a queue that the stimulus process fills.
// A clocked monitor mirrors every accepted atom and register write into a
// software copy of the find-and-replace window. It also checks each word that
// leaves the block against the oldest predicted word. Directed phases cover
// the field extremes and the corner cases of the register settings. Random
// phases then run mostly well-formed pattern occurrences with random labels,
// mixed with partial matches and noise. Both sides insert random gaps.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TOTAL_ATOMS    = 324;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 3000;

    // Indexes past the register list; writes to them must be ignored.
    localparam logic [gprs_pkg::CFG_ADDR_W-1:0] REG_UNMAPPED     = 3'd5;
    localparam logic [gprs_pkg::CFG_ADDR_W-1:0] REG_UNMAPPED_TOP = 3'd7;

    localparam logic [63:0] DIR_PATTERN = 64'hFF80_7F01_00C3_3CA5;

    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] lab;
        logic       last;
    } in_atom_t;

    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] lab;
        logic       run_last;
        logic       stream_end;
    } word_t;

    logic                            aclk;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [7:0]                      s_char = 8'h00;
    logic signed [7:0]               s_label = 8'sh00;
    logic                            s_last = 1'b0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [7:0]                      m_char;
    logic signed [7:0]               m_label;
    logic                            m_run_last;
    logic                            m_stream_end;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [gprs_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [63:0]                     cfg_data = '0;

    in_atom_t atom_q[$];
    word_t    due_words[$];
    int       atoms_sent = 0;
    int       mismatches = 0;
    int       quiet_cycles = 0;
    int       gap_left = 0;
    int       stall_left = 0;
    logic     in_taken = 1'b0;
    logic     calm = 1'b0;
    in_atom_t nxt;
    word_t    want;

    // Shadow of the block's registers and window.
    logic [3:0]      sh_plen = 4'd1;
    logic [63:0]     sh_pat = '0;
    logic [3:0]      sh_rlen = 4'd0;
    logic [63:0]     sh_rbytes = '0;
    logic [63:0]     sh_rlabels = '1;
    gprs_pkg::atom_t win_atoms[gprs_pkg::BYTES_MAX];
    int unsigned     win_fill = 0;

    greedy_pattern_replace_stream u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char      (s_char),
        .s_label     (s_label),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char      (m_char),
        .m_label     (m_label),
        .m_run_last  (m_run_last),
        .m_stream_end(m_stream_end),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int unsigned plen_eff(input logic [3:0] v);
        int unsigned p;
        p = v;
        if (p == 0) p = 1;
        if (p > gprs_pkg::MAX_PATTERN_DEF) p = gprs_pkg::MAX_PATTERN_DEF;
        if (p > gprs_pkg::BYTES_MAX) p = gprs_pkg::BYTES_MAX;
        return p;
    endfunction

    function automatic word_t mk_word(input logic [7:0] ch, input logic [7:0] lab);
        word_t w;
        w.ch = ch;
        w.lab = lab;
        w.run_last = 1'b0;
        w.stream_end = 1'b0;
        return w;
    endfunction

    // Window step for one accepted atom; appends the predicted words.
    function automatic void match_and_replace(input logic [7:0] ch, input logic [7:0] lab,
                                              input logic last);
        int unsigned p;
        int unsigned r;
        bit          hit;
        word_t       produced[$];
        word_t       w;
        p = plen_eff(sh_plen);
        if (win_fill >= p) win_fill = 0;
        win_atoms[win_fill] = {lab, ch};
        win_fill++;
        if (win_fill >= p) begin
            hit = 1'b1;
            for (int k = 0; k < p; k++) begin
                if (win_atoms[k].ch != sh_pat[8*k +: 8]) hit = 1'b0;
            end
            if (hit) begin
                r = sh_rlen;
                if (r > gprs_pkg::MAX_REPL_DEF) r = gprs_pkg::MAX_REPL_DEF;
                if (r > gprs_pkg::BYTES_MAX) r = gprs_pkg::BYTES_MAX;
                for (int k = 0; k < r; k++) begin
                    produced.push_back(mk_word(sh_rbytes[8*k +: 8], sh_rlabels[8*k +: 8]));
                end
                win_fill = 0;
            end else begin
                produced.push_back(mk_word(win_atoms[0].ch, win_atoms[0].lab));
                for (int k = 1; k < win_fill; k++) win_atoms[k-1] = win_atoms[k];
                win_fill--;
            end
        end
        if (last) begin
            for (int k = 0; k < win_fill; k++) begin
                produced.push_back(mk_word(win_atoms[k].ch, win_atoms[k].lab));
            end
            win_fill = 0;
        end
        if (produced.size() != 0) begin
            w = produced.pop_back();
            w.run_last = 1'b1;
            w.stream_end = last;
            produced.push_back(w);
        end
        foreach (produced[i]) due_words.push_back(produced[i]);
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_pause(input logic quiet);
        int sel;
        sel = $urandom_range(0, 99);
        if (quiet || sel < 55) return 0;
        if (sel < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_label();
        logic [7:0] v;
        v = 8'($urandom_range(0, 127));
        if ($urandom_range(0, 3) == 0) v = 8'hFF;
        return v;
    endfunction

    function automatic logic rand_last();
        return $urandom_range(0, 15) == 0;
    endfunction

    function automatic void push_atom(input logic [7:0] ch, input logic [7:0] lab,
                                      input logic last);
        atom_q.push_back({ch, lab, last});
        atoms_sent++;
    endfunction

    task automatic write_reg(input logic [gprs_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [63:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every queued atom is taken and every predicted word has
    // arrived, then lets atoms that produce no word finish inside the block.
    task automatic wait_idle();
        do @(posedge aclk); while (atom_q.size() != 0 || s_valid || due_words.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Atom driver.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = 0;
        end else if (!s_valid || in_taken) begin
            if (gap_left != 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (atom_q.size() != 0) begin
                nxt = atom_q.pop_front();
                s_char  <= nxt.ch;
                s_label <= nxt.lab;
                s_last  <= nxt.last;
                s_valid <= 1'b1;
                gap_left = pick_pause(calm);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Back pressure on the word channel.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 25) stall_left = pick_pause(1'b0);
        end
    end

    // Monitor: predicts on accepted atoms, checks accepted words.
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_taken <= 1'b0;
            quiet_cycles = 0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    gprs_pkg::REG_PATTERN_LEN: begin
                        sh_plen = cfg_data[3:0];
                        win_fill = 0;
                    end
                    gprs_pkg::REG_PATTERN_BYTES: sh_pat = cfg_data;
                    gprs_pkg::REG_REPL_LEN:      sh_rlen = cfg_data[3:0];
                    gprs_pkg::REG_REPL_BYTES:    sh_rbytes = cfg_data;
                    gprs_pkg::REG_REPL_LABELS:   sh_rlabels = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) match_and_replace(s_char, s_label, s_last);
            if (m_valid && m_ready) begin
                if (due_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: char %02h label %0d run_last %0b end %0b",
                                 m_char, m_label, m_run_last, m_stream_end);
                end else begin
                    want = due_words.pop_front();
                    if (m_char !== want.ch || m_label !== want.lab ||
                        m_run_last !== want.run_last || m_stream_end !== want.stream_end) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"word mismatch: expected char %02h label %0d run_last %0b",
                                      " end %0b, got char %02h label %0d run_last %0b end %0b"},
                                     want.ch, $signed(want.lab), want.run_last, want.stream_end,
                                     m_char, m_label, m_run_last, m_stream_end);
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        int          ph;
        int          n;
        int          cnt;
        int          m;
        int          sel;
        int unsigned st_plen;
        logic [63:0] st_pat;
        logic [63:0] data;
        logic [7:0]  c;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: one-character pattern 0x00, matches deleted.
        // The third atom is a silent end: it is deleted and carries the last flag.
        push_atom(8'h00, 8'hFF, 1'b0);
        push_atom(8'hFF, 8'h7F, 1'b0);
        push_atom(8'h00, 8'h00, 1'b1);
        push_atom(8'h55, 8'hFF, 1'b1);
        wait_idle();

        // Zero pattern length acts as one; replacement length saturates at eight.
        write_reg(gprs_pkg::REG_PATTERN_LEN, 64'd0);
        write_reg(gprs_pkg::REG_PATTERN_BYTES, 64'h41);
        write_reg(gprs_pkg::REG_REPL_LEN, 64'hF);
        write_reg(gprs_pkg::REG_REPL_BYTES, 64'h0123_4567_89AB_CDEF);
        write_reg(gprs_pkg::REG_REPL_LABELS, 64'h0810_2040_01FF_007F);
        write_reg(REG_UNMAPPED, '1);
        write_reg(REG_UNMAPPED_TOP, 64'h5);
        @(posedge aclk);
        push_atom(8'h41, 8'h05, 1'b0);
        push_atom(8'h42, 8'hFF, 1'b0);
        push_atom(8'h41, 8'h7F, 1'b1);
        wait_idle();

        // Pattern length saturates at eight. The trailing prefix stays buffered
        // and is dropped by the next pattern length write.
        write_reg(gprs_pkg::REG_PATTERN_LEN, 64'hF);
        write_reg(gprs_pkg::REG_PATTERN_BYTES, DIR_PATTERN);
        write_reg(gprs_pkg::REG_REPL_LEN, 64'd1);
        write_reg(gprs_pkg::REG_REPL_BYTES, 64'h5A);
        write_reg(gprs_pkg::REG_REPL_LABELS, 64'hFF);
        @(posedge aclk);
        for (int k = 0; k < 8; k++) push_atom(DIR_PATTERN[8*k +: 8], rand_label(), 1'b0);
        for (int k = 0; k < 3; k++) push_atom(DIR_PATTERN[8*k +: 8], rand_label(), 1'b0);
        wait_idle();

        write_reg(gprs_pkg::REG_PATTERN_LEN, 64'd3);
        write_reg(gprs_pkg::REG_PATTERN_BYTES, 64'h63_6261);
        write_reg(gprs_pkg::REG_REPL_LEN, 64'd0);
        @(posedge aclk);
        push_atom(8'h78, 8'h00, 1'b0);
        push_atom(8'h61, 8'h01, 1'b0);
        push_atom(8'h62, 8'h02, 1'b0);
        push_atom(8'h63, 8'h03, 1'b0);
        push_atom(8'h61, 8'hFF, 1'b0);
        push_atom(8'h62, 8'h7F, 1'b1);
        st_plen = 3;
        st_pat = 64'h63_6261;

        ph = 0;
        while (atoms_sent < TOTAL_ATOMS) begin
            wait_idle();
            calm = ($urandom_range(0, 4) == 0);
            if (ph < 2 || $urandom_range(0, 3) != 0) begin
                data = {$urandom(), $urandom()};
                if (ph == 0) data[3:0] = 4'd8;
                else if (ph == 1) data[3:0] = 4'd1;
                else begin
                    sel = $urandom_range(0, 9);
                    if (sel == 0) data[3:0] = 4'd0;
                    else if (sel == 1) data[3:0] = 4'hF;
                    else if (sel == 2) data[3:0] = 4'd8;
                    else data[3:0] = 4'($urandom_range(1, 4));
                end
                write_reg(gprs_pkg::REG_PATTERN_LEN, data);
                st_plen = plen_eff(data[3:0]);
            end
            st_pat = {$urandom(), $urandom()};
            write_reg(gprs_pkg::REG_PATTERN_BYTES, st_pat);
            data = {$urandom(), $urandom()};
            if (ph == 0) data[3:0] = 4'd8;
            else if (ph == 1) data[3:0] = 4'd0;
            else data[3:0] = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                          : 4'($urandom_range(0, 3));
            write_reg(gprs_pkg::REG_REPL_LEN, data);
            write_reg(gprs_pkg::REG_REPL_BYTES, {$urandom(), $urandom()});
            write_reg(gprs_pkg::REG_REPL_LABELS, {$urandom(), $urandom()});
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_UNMAPPED + 3'($urandom_range(0, 2)), {$urandom(), $urandom()});
            @(posedge aclk);

            n = $urandom_range(20, 45);
            cnt = 0;
            while (cnt < n) begin
                sel = $urandom_range(0, 99);
                if (sel < 55) begin
                    for (int k = 0; k < st_plen; k++)
                        push_atom(st_pat[8*k +: 8], rand_label(), rand_last());
                    cnt += st_plen;
                end else if (sel < 65 && st_plen > 1) begin
                    m = $urandom_range(1, st_plen - 1);
                    for (int k = 0; k < m; k++)
                        push_atom(st_pat[8*k +: 8], rand_label(), rand_last());
                    push_atom(8'($urandom_range(0, 255)), rand_label(), rand_last());
                    cnt += m + 1;
                end else begin
                    m = $urandom_range(0, st_plen - 1);
                    c = $urandom_range(0, 1) ? st_pat[8*m +: 8] : 8'($urandom_range(0, 255));
                    push_atom(c, rand_label(), rand_last());
                    cnt++;
                end
            end
            ph++;
        end

        wait_idle();
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
